FILE: src/point_table_radius_search_macros.svh
// assertion macros for the point table radius search block
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef POINT_TABLE_RADIUS_SEARCH_MACROS_SVH
`define POINT_TABLE_RADIUS_SEARCH_MACROS_SVH

// property that holds at every clock edge outside reset
`define PTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ptrs_pkg.sv
// shared types and codes for the point table radius search block
// no dependencies; used by the cell, the top level and the verification files
package ptrs_pkg;

  // operation codes
  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_INVALIDATE = 3'd1;
  localparam logic [2:0] OP_MOVE_LAST  = 3'd2;
  localparam logic [2:0] OP_SEARCH     = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // request payload
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [7:0]  class_label;
    logic [15:0] cost_value;
    logic [5:0]  entry_index;
    logic [15:0] radius;
  } cmd_t;

  // result payload
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        last;
  } result_t;

  // per-cell control
  typedef struct packed {
    logic shift;    // take the neighbor's entry
    logic load;     // write a whole new entry
    logic load_xy;  // rewrite coordinates only
    logic clear;    // drop the valid mark
  } cell_ctrl_t;

endpackage

FILE: src/ptrs_cell.sv
// one table cell: a stored entry that can be written or shifted from its neighbor
// depends on ptrs_pkg
module ptrs_cell #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptrs_pkg::cell_ctrl_t   ctrl_i,
  input  logic [COORD_BITS-1:0]  wr_x_i,
  input  logic [COORD_BITS-1:0]  wr_y_i,
  input  logic [7:0]             wr_label_i,
  input  logic [15:0]            wr_cost_i,
  input  logic                   nb_valid_i,
  input  logic [COORD_BITS-1:0]  nb_x_i,
  input  logic [COORD_BITS-1:0]  nb_y_i,
  input  logic [7:0]             nb_label_i,
  input  logic [15:0]            nb_cost_i,
  output logic                   valid_o,
  output logic [COORD_BITS-1:0]  x_o,
  output logic [COORD_BITS-1:0]  y_o,
  output logic [7:0]             label_o,
  output logic [15:0]            cost_o
);

  logic                  valid_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [7:0]            label_q;
  logic [15:0]           cost_q;

  // valid mark, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nb_valid_i;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      x_q     <= nb_x_i;
      y_q     <= nb_y_i;
      label_q <= nb_label_i;
      cost_q  <= nb_cost_i;
    end else if (ctrl_i.load) begin
      x_q     <= wr_x_i;
      y_q     <= wr_y_i;
      label_q <= wr_label_i;
      cost_q  <= wr_cost_i;
    end else if (ctrl_i.load_xy) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign label_o = label_q;
  assign cost_o  = cost_q;

endmodule

FILE: src/ptrs_eval.sv
// match evaluator at the head of the cell chain: distance or label/cost test
// two register stages: abs difference, then squares; compare after the second
module ptrs_eval #(
  parameter  int unsigned TABLE_DEPTH = 64,
  parameter  int unsigned COORD_BITS  = 16,
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  present_i,
  input  logic                  list_mode_i,
  input  logic [COORD_BITS-1:0] qx_i,
  input  logic [COORD_BITS-1:0] qy_i,
  input  logic [31:0]           r2_i,
  input  logic [7:0]            qlabel_i,
  input  logic [15:0]           qcost_i,
  input  logic                  e_valid_i,
  input  logic [COORD_BITS-1:0] e_x_i,
  input  logic [COORD_BITS-1:0] e_y_i,
  input  logic [7:0]            e_label_i,
  input  logic [15:0]           e_cost_i,
  input  logic [IW-1:0]         e_idx_i,
  output logic                  hit_o,
  output logic [IW-1:0]         hit_idx_o,
  output logic [COORD_BITS-1:0] hit_x_o,
  output logic [COORD_BITS-1:0] hit_y_o,
  output logic                  busy_o
);

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned SW = (PW + 1 > 32) ? PW + 1 : 32;

  logic                  v1_q, v2_q;
  logic                  m1_d, m1_q, m2_q;
  logic [IW-1:0]         idx1_q, idx2_q;
  logic [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [COORD_BITS-1:0] dx_d, dy_d, dx1_q, dy1_q;
  logic [PW-1:0]         sqx_d, sqy_d, sqx2_q, sqy2_q;
  logic [SW-1:0]         dist_sum;

  // entry qualifies before the distance test
  assign m1_d = e_valid_i &
                (~list_mode_i | ((e_label_i == qlabel_i) & (e_cost_i > qcost_i)));
  assign dx_d = (e_x_i > qx_i) ? (e_x_i - qx_i) : (qx_i - e_x_i);
  assign dy_d = (e_y_i > qy_i) ? (e_y_i - qy_i) : (qy_i - e_y_i);

  // squares of the differences
  assign sqx_d = PW'(dx1_q) * PW'(dx1_q);
  assign sqy_d = PW'(dy1_q) * PW'(dy1_q);

  // stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= present_i;
      v2_q <= v1_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    m1_q   <= m1_d;
    idx1_q <= e_idx_i;
    x1_q   <= e_x_i;
    y1_q   <= e_y_i;
    dx1_q  <= dx_d;
    dy1_q  <= dy_d;
    m2_q   <= m1_q;
    idx2_q <= idx1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    sqx2_q <= sqx_d;
    sqy2_q <= sqy_d;
  end

  // squared distance against squared radius; list mode skips the distance test
  assign dist_sum  = SW'(sqx2_q) + SW'(sqy2_q);
  assign hit_o     = v2_q & m2_q & (list_mode_i | (dist_sum < SW'(r2_i)));
  assign hit_idx_o = idx2_q;
  assign hit_x_o   = x2_q;
  assign hit_y_o   = y2_q;
  assign busy_o    = v1_q | v2_q;

endmodule

FILE: src/point_table_radius_search.sv
// top level of the point table radius search block
// depends on ptrs_pkg, ptrs_cell, ptrs_eval and the assertion macro header
//
//   channel   direction  handshake        payload
//   request   in         start_i, busy_o  cmd_i    (ptrs_pkg::cmd_t)
//   result    out        valid_o          result_o (ptrs_pkg::result_t)
//
// append, invalidate and move last answer in the cycle after the request and busy_o stays low
// search and list rotate the cell chain once past the evaluator, one entry a cycle,
// then drain its two stages before busy_o falls
// list results come out during the walk; the final one follows the drain
// reset clears the valid marks and entry count at once; there is no clearing pass
// valid_o holds for one cycle and the receiver cannot stall it
`include "point_table_radius_search_macros.svh"

module point_table_radius_search #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ptrs_pkg::cmd_t    cmd_i,
  output logic              busy_o,
  output logic              valid_o,
  output ptrs_pkg::result_t result_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [IW-1:0]         rot_q, rot_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  accept;
  logic                  tbl_full, tbl_empty, inv_ok;
  logic [COORD_BITS-1:0] px, py;

  // query held during a walk
  logic                  q_load;
  logic                  q_list_q;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic [31:0]           r2_q;
  logic [7:0]            qlabel_q;
  logic [15:0]           qcost_q;

  // pending match, held until the next one (list only) or the end of the walk
  logic                  pend_v_q, pend_v_d;
  logic [IW-1:0]         pend_idx_q, pend_idx_d;
  logic [COORD_BITS-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;

  // result register
  logic                  res_v_q, res_v_d;
  ptrs_pkg::result_t     res_q, res_d;

  // cell chain
  ptrs_pkg::cell_ctrl_t  cell_ctrl [TABLE_DEPTH];
  logic                  c_valid   [TABLE_DEPTH];
  logic [COORD_BITS-1:0] c_x       [TABLE_DEPTH];
  logic [COORD_BITS-1:0] c_y       [TABLE_DEPTH];
  logic [7:0]            c_label   [TABLE_DEPTH];
  logic [15:0]           c_cost    [TABLE_DEPTH];

  // evaluator
  logic                  hit, eval_busy;
  logic [IW-1:0]         hit_idx;
  logic [COORD_BITS-1:0] hit_x, hit_y;

  assign accept    = start_i & ~busy_o;
  assign tbl_full  = (count_q == CW'(TABLE_DEPTH));
  assign tbl_empty = (count_q == '0);
  assign inv_ok    = (7'(cmd_i.entry_index) < 7'(count_q));
  assign px        = COORD_BITS'(cmd_i.point_x);
  assign py        = COORD_BITS'(cmd_i.point_y);

  // cells; cell k takes its entry from cell k+1, the last cell from cell 0
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned NB = (i + 1) % TABLE_DEPTH;

    always_comb begin
      cell_ctrl[i].shift   = (state_q == S_SCAN);
      cell_ctrl[i].load    = accept & (cmd_i.opcode == ptrs_pkg::OP_APPEND) &
                             ~tbl_full & (count_q == CW'(i));
      cell_ctrl[i].load_xy = accept & (cmd_i.opcode == ptrs_pkg::OP_MOVE_LAST) &
                             (count_q == CW'(i + 1));
      cell_ctrl[i].clear   = accept & (cmd_i.opcode == ptrs_pkg::OP_INVALIDATE) &
                             inv_ok & (cmd_i.entry_index == 6'(i));
    end

    ptrs_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[i]),
      .wr_x_i     (px),
      .wr_y_i     (py),
      .wr_label_i (cmd_i.class_label),
      .wr_cost_i  (cmd_i.cost_value),
      .nb_valid_i (c_valid[NB]),
      .nb_x_i     (c_x[NB]),
      .nb_y_i     (c_y[NB]),
      .nb_label_i (c_label[NB]),
      .nb_cost_i  (c_cost[NB]),
      .valid_o    (c_valid[i]),
      .x_o        (c_x[i]),
      .y_o        (c_y[i]),
      .label_o    (c_label[i]),
      .cost_o     (c_cost[i])
    );
  end

  // evaluator watches the head cell
  ptrs_eval #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .present_i   (state_q == S_SCAN),
    .list_mode_i (q_list_q),
    .qx_i        (qx_q),
    .qy_i        (qy_q),
    .r2_i        (r2_q),
    .qlabel_i    (qlabel_q),
    .qcost_i     (qcost_q),
    .e_valid_i   (c_valid[0]),
    .e_x_i       (c_x[0]),
    .e_y_i       (c_y[0]),
    .e_label_i   (c_label[0]),
    .e_cost_i    (c_cost[0]),
    .e_idx_i     (rot_q),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .hit_x_o     (hit_x),
    .hit_y_o     (hit_y),
    .busy_o      (eval_busy)
  );

  // control and result selection
  always_comb begin
    state_d    = state_q;
    rot_d      = rot_q;
    count_d    = count_q;
    q_load     = 1'b0;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    res_v_d    = 1'b0;
    res_d      = '0;
    res_d.last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.opcode)
            ptrs_pkg::OP_APPEND: begin
              res_v_d = 1'b1;
              if (tbl_full) begin
                res_d.status = ptrs_pkg::STAT_FULL;
              end else begin
                res_d.found_index = 6'(count_q);
                count_d           = count_q + 1'b1;
              end
            end
            ptrs_pkg::OP_INVALIDATE: begin
              res_v_d = 1'b1;
              if (inv_ok) begin
                res_d.found_index = cmd_i.entry_index;
              end else begin
                res_d.status = ptrs_pkg::STAT_RANGE;
              end
            end
            ptrs_pkg::OP_MOVE_LAST: begin
              res_v_d = 1'b1;
              if (tbl_empty) begin
                res_d.status = ptrs_pkg::STAT_NOT_FOUND;
              end else begin
                res_d.found_index = 6'(count_q - 1'b1);
              end
            end
            ptrs_pkg::OP_SEARCH, ptrs_pkg::OP_LIST: begin
              state_d  = S_SCAN;
              rot_d    = '0;
              pend_v_d = 1'b0;
              q_load   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rot_d = rot_q + 1'b1;
        if (rot_q == IW'(TABLE_DEPTH - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!eval_busy) begin
          state_d = S_IDLE;
          res_v_d = 1'b1;
          if (pend_v_q) begin
            res_d.found_index = 6'(pend_idx_q);
            res_d.out_x       = 16'(pend_x_q);
            res_d.out_y       = 16'(pend_y_q);
          end else begin
            res_d.status = ptrs_pkg::STAT_NOT_FOUND;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // matches from the evaluator; search keeps the first, list flushes the older one
    if (hit && (q_list_q || !pend_v_q)) begin
      if (q_list_q && pend_v_q) begin
        res_v_d           = 1'b1;
        res_d.found_index = 6'(pend_idx_q);
        res_d.out_x       = 16'(pend_x_q);
        res_d.out_y       = 16'(pend_y_q);
        res_d.last        = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_idx_d = hit_idx;
      pend_x_d   = hit_x;
      pend_y_d   = hit_y;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rot_q    <= '0;
      count_q  <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rot_q    <= rot_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    res_q      <= res_d;
    if (q_load) begin
      q_list_q <= (cmd_i.opcode == ptrs_pkg::OP_LIST);
      qx_q     <= px;
      qy_q     <= py;
      r2_q     <= 32'(cmd_i.radius) * 32'(cmd_i.radius);
      qlabel_q <= cmd_i.class_label;
      qcost_q  <= cmd_i.cost_value;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign valid_o  = res_v_q;
  assign result_o = res_q;

  // checks
  `PTRS_ASSERT(a_count_bound, count_q <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `PTRS_ASSERT_NEXT(a_walk_length, (state_q == S_SCAN) && (rot_q != IW'(TABLE_DEPTH - 1)), state_q == S_SCAN, "walk ended before a full rotation")
  `PTRS_ASSERT(a_search_single, (valid_o && !result_o.last) |-> q_list_q, "non-final result outside a list")
  `PTRS_ASSERT(a_fail_fields, (valid_o && (result_o.status != ptrs_pkg::STAT_OK)) |-> (result_o.found_index == 6'd0) && result_o.last, "failed request carries index or is not last")

endmodule

FILE: verif/ptrs_result_checker.sv
`timescale 1ns / 1ps
// result checker for the point table radius search block: watches the request
// and result channels, keeps its own copy of the point table and compares each
// result with the oldest expected one; depends on ptrs_pkg
module ptrs_result_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  ptrs_pkg::cmd_t    cmd_i,
  input  logic              valid_i,
  input  ptrs_pkg::result_t result_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  // shadow copy of the table
  logic [15:0]            x_tab     [TABLE_DEPTH];
  logic [15:0]            y_tab     [TABLE_DEPTH];
  logic [7:0]             label_tab [TABLE_DEPTH];
  logic [15:0]            cost_tab  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] live_mask;
  int unsigned            fill_level;

  ptrs_pkg::result_t pending_results[$];
  int unsigned       fail_count;
  int unsigned       pending_level;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_level;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic push_result(input logic [1:0] st, input logic [5:0] idx,
                             input logic [15:0] px, input logic [15:0] py,
                             input logic lst);
    ptrs_pkg::result_t r;
    r.status      = st;
    r.found_index = idx;
    r.out_x       = px;
    r.out_y       = py;
    r.last        = lst;
    pending_results = {pending_results, r};
  endtask

  // apply one accepted request to the shadow table and queue its results
  task automatic predict_request(input ptrs_pkg::cmd_t c);
    int unsigned       i;
    int unsigned       hits;
    logic [15:0]       dx, dy;
    logic [33:0]       dist_sq, radius_sq;
    ptrs_pkg::result_t r;
    case (c.opcode)
      ptrs_pkg::OP_APPEND: begin
        if (fill_level >= TABLE_DEPTH) begin
          push_result(ptrs_pkg::STAT_FULL, '0, '0, '0, 1'b1);
        end else begin
          x_tab[fill_level]     = c.point_x;
          y_tab[fill_level]     = c.point_y;
          label_tab[fill_level] = c.class_label;
          cost_tab[fill_level]  = c.cost_value;
          live_mask[fill_level] = 1'b1;
          push_result(ptrs_pkg::STAT_OK, 6'(fill_level), '0, '0, 1'b1);
          fill_level++;
        end
      end
      ptrs_pkg::OP_INVALIDATE: begin
        if (c.entry_index >= fill_level) begin
          push_result(ptrs_pkg::STAT_RANGE, '0, '0, '0, 1'b1);
        end else begin
          live_mask[c.entry_index] = 1'b0;
          push_result(ptrs_pkg::STAT_OK, c.entry_index, '0, '0, 1'b1);
        end
      end
      ptrs_pkg::OP_MOVE_LAST: begin
        if (fill_level == 0) begin
          push_result(ptrs_pkg::STAT_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          x_tab[fill_level-1] = c.point_x;
          y_tab[fill_level-1] = c.point_y;
          push_result(ptrs_pkg::STAT_OK, 6'(fill_level - 1), '0, '0, 1'b1);
        end
      end
      ptrs_pkg::OP_SEARCH: begin
        // first live entry strictly inside the circle wins
        radius_sq = 34'(c.radius) * 34'(c.radius);
        hits = 0;
        for (i = 0; i < fill_level; i++) begin
          if (live_mask[i]) begin
            dx = (x_tab[i] > c.point_x) ? x_tab[i] - c.point_x : c.point_x - x_tab[i];
            dy = (y_tab[i] > c.point_y) ? y_tab[i] - c.point_y : c.point_y - y_tab[i];
            dist_sq = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
            if (dist_sq < radius_sq) begin
              push_result(ptrs_pkg::STAT_OK, 6'(i), x_tab[i], y_tab[i], 1'b1);
              hits = 1;
              break;
            end
          end
        end
        if (hits == 0) push_result(ptrs_pkg::STAT_NOT_FOUND, '0, '0, '0, 1'b1);
      end
      ptrs_pkg::OP_LIST: begin
        // every live entry with this label and a cost above the threshold
        hits = 0;
        for (i = 0; i < fill_level; i++) begin
          if (live_mask[i] && label_tab[i] == c.class_label &&
              cost_tab[i] > c.cost_value) begin
            push_result(ptrs_pkg::STAT_OK, 6'(i), x_tab[i], y_tab[i], 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          push_result(ptrs_pkg::STAT_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results = {pending_results, r};
        end
      end
      default: begin
        // unused opcodes leave the table alone and answer nothing
      end
    endcase
  endtask

  // compare results first, then take the request of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    ptrs_pkg::result_t want;
    if (!rst_ni) begin
      live_mask     = '0;
      fill_level    = 0;
      fail_count    = 0;
      pending_results.delete();
      pending_level = 0;
    end else begin
      if (valid_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", result_i.status, 0);
        end else begin
          want = pending_results.pop_front();
          if (result_i.status !== want.status)
            report_mismatch("status", result_i.status, want.status);
          if (result_i.found_index !== want.found_index)
            report_mismatch("found_index", result_i.found_index, want.found_index);
          if (result_i.out_x !== want.out_x)
            report_mismatch("out_x", result_i.out_x, want.out_x);
          if (result_i.out_y !== want.out_y)
            report_mismatch("out_y", result_i.out_y, want.out_y);
          if (result_i.last !== want.last)
            report_mismatch("last", result_i.last, want.last);
        end
      end
      if (start_i && !busy_i) predict_request(cmd_i);
      pending_level = pending_results.size();
    end
  end

endmodule

FILE: verif/tb_point_table_radius_search.sv
`timescale 1ns / 1ps
// testbench top for the point table radius search block: drives directed and
// random requests in bursts and gives the verdict; depends on ptrs_pkg, the
// block and ptrs_result_checker
module tb_point_table_radius_search;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS  = 395;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

  // opcodes with no operation behind them
  localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
  localparam logic [2:0] OP_RESERVED_MID = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI  = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  ptrs_pkg::cmd_t    cmd_i;
  logic              busy_o;
  logic              valid_o;
  ptrs_pkg::result_t result_o;
  int unsigned       fail_count;
  int unsigned       pending_count;

  // stimulus-side bookkeeping, used only to aim requests at stored points
  logic [15:0] aim_x[$];
  logic [15:0] aim_y[$];
  int unsigned stored_count;
  int unsigned burst_left;

  point_table_radius_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (16)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  ptrs_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .cmd_i       (cmd_i),
    .valid_i     (valid_o),
    .result_i    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", pending_count);
    $display("Test completed with failures");
    $finish;
  end

  function automatic ptrs_pkg::cmd_t make_cmd(input logic [2:0] op, input logic [15:0] px,
                                              input logic [15:0] py, input logic [7:0] lab,
                                              input logic [15:0] cost, input logic [5:0] idx,
                                              input logic [15:0] rad);
    ptrs_pkg::cmd_t c;
    c.opcode      = op;
    c.point_x     = px;
    c.point_y     = py;
    c.class_label = lab;
    c.cost_value  = cost;
    c.entry_index = idx;
    c.radius      = rad;
    return c;
  endfunction

  // send one request; bursts of back-to-back requests with random gaps between
  task automatic issue(input ptrs_pkg::cmd_t c);
    logic accepted;
    if (burst_left == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    start_i = 1'b1;
    cmd_i   = c;
    if (c.opcode == ptrs_pkg::OP_APPEND && stored_count < TABLE_DEPTH) begin
      aim_x = {aim_x, c.point_x};
      aim_y = {aim_y, c.point_y};
      stored_count++;
    end
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !busy_o;
    end
    @(negedge clk_i);
  endtask

  // random request; searches and invalidates mostly aimed at stored points, labels mostly a few
  function automatic ptrs_pkg::cmd_t random_cmd();
    ptrs_pkg::cmd_t c;
    int unsigned    pick, k;
    c.opcode      = ptrs_pkg::OP_APPEND;
    c.point_x     = 16'($urandom);
    c.point_y     = 16'($urandom);
    c.class_label = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.cost_value  = 16'($urandom);
    c.entry_index = 6'($urandom);
    c.radius      = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 26)      c.opcode = ptrs_pkg::OP_APPEND;
    else if (pick < 38) c.opcode = ptrs_pkg::OP_INVALIDATE;
    else if (pick < 46) c.opcode = ptrs_pkg::OP_MOVE_LAST;
    else if (pick < 71) c.opcode = ptrs_pkg::OP_SEARCH;
    else if (pick < 95) c.opcode = ptrs_pkg::OP_LIST;
    else                c.opcode = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    if (c.opcode == ptrs_pkg::OP_INVALIDATE && stored_count > 0 && $urandom_range(0, 9) < 7)
      c.entry_index = 6'($urandom_range(0, stored_count - 1));
    if (c.opcode == ptrs_pkg::OP_LIST && $urandom_range(0, 1) == 0)
      c.cost_value = 16'($urandom_range(0, 16'h8000));
    if (c.opcode == ptrs_pkg::OP_SEARCH && aim_x.size() > 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, aim_x.size() - 1);
      c.point_x = aim_x[k] + 16'($urandom_range(0, 64)) - 16'd32;
      c.point_y = aim_y[k] + 16'($urandom_range(0, 64)) - 16'd32;
      c.radius  = 16'($urandom_range(0, 48));
    end
    return c;
  endfunction

  initial begin
    ptrs_pkg::cmd_t c;
    int unsigned    sent;
    int unsigned    waited;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    cmd_i        = '0;
    stored_count = 0;
    burst_left   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table: search, list, move last and invalidate on nothing
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'hffff));
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_MOVE_LAST, 16'h1234, 16'h5678, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_INVALIDATE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    // field extremes on append
    issue(make_cmd(ptrs_pkg::OP_APPEND, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_APPEND, 16'hffff, 16'hffff, 8'hff, 16'hffff, 6'd63,
                   16'hffff));
    issue(make_cmd(ptrs_pkg::OP_APPEND, 16'd100, 16'd200, 8'h05, 16'h0180, 6'd0,
                   16'h0000));
    // radius zero never matches, radius one matches an exact hit
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'd100, 16'd200, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'd100, 16'd200, 8'h00, 16'h0000, 6'd0,
                   16'h0001));
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'hffff));
    // distance exactly equal to the radius is outside
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'hffff, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'hffff));
    // cost must be strictly above the threshold
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'h05, 16'h017f, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'h05, 16'h0180, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'hff, 16'hfffe, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    // invalidate twice, then the search must skip the cleared entry
    issue(make_cmd(ptrs_pkg::OP_INVALIDATE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_INVALIDATE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_SEARCH, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0,
                   16'hffff));
    issue(make_cmd(ptrs_pkg::OP_MOVE_LAST, 16'd300, 16'd400, 8'h00, 16'h0000, 6'd0,
                   16'h0000));
    // out of range indexes: the top one and the first unused one
    issue(make_cmd(ptrs_pkg::OP_INVALIDATE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd63,
                   16'h0000));
    issue(make_cmd(ptrs_pkg::OP_INVALIDATE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd3,
                   16'h0000));
    // unused opcodes
    issue(make_cmd(OP_RESERVED_LO, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0, 16'h0000));
    issue(make_cmd(OP_RESERVED_MID, 16'hffff, 16'hffff, 8'hff, 16'hffff, 6'd63, 16'hffff));
    issue(make_cmd(OP_RESERVED_HI, 16'h0000, 16'h0000, 8'h00, 16'h0000, 6'd0, 16'h0000));
    // list with several hits
    issue(make_cmd(ptrs_pkg::OP_APPEND, 16'd7, 16'd7, 8'h05, 16'hffff, 6'd0, 16'h0000));
    issue(make_cmd(ptrs_pkg::OP_LIST, 16'h0000, 16'h0000, 8'h05, 16'h0000, 6'd0,
                   16'h0000));

    // random part; the table fills up along the way
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c = random_cmd();
      issue(c);
      sent++;
    end
    start_i = 1'b0;

    // drain
    waited = 0;
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_count != 0) begin
      $display("%0d expected results never arrived", pending_count);
      $display("Test completed with failures");
      $finish;
    end else begin
      repeat (TABLE_DEPTH + 8) @(posedge clk_i);
      if (fail_count == 0)
        $display("Test completed successfully");
      else
        $display("Test completed with failures");
      $finish;
    end
  end

endmodule
